// File: sv/fbc_pkg.sv
package fbc_pkg;

  // Operation codes of an input transaction
  typedef enum logic {
    OP_START   = 1'b0,
    OP_PAYLOAD = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_LONG = 2'd1,
    STATUS_NO_FRAME = 2'd2
  } status_t;

  // Input transaction payload
  typedef struct packed {
    op_t         operation;
    logic [7:0]  frame_type;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_frame;
    status_t    status;
  } out_item_t;

  // Command kinds passed from front to back
  typedef enum logic [1:0] {
    CMD_START    = 2'd0,
    CMD_DATA     = 2'd1,
    CMD_REFUSE   = 2'd2,
    CMD_NO_FRAME = 2'd3
  } cmd_kind_t;

  // Queued command: value is the type byte (start) or the payload byte (data);
  // with_trailer marks a zero-length start or the final payload byte
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  value;
    logic [15:0] length;
    logic        with_trailer;
  } cmd_t;

  // Register indexes (byte address 4*i)
  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_VERSION     = 2'd2,
    REG_MAX_PAYLOAD = 2'd3
  } reg_idx_t;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
  localparam logic [7:0]  VERSION_RST     = 8'h01;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Command queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Emission steps of the back sequencer
  typedef logic [2:0] step_t;
  localparam step_t STEP_SYNC_FIRST  = 3'd0;
  localparam step_t STEP_SYNC_SECOND = 3'd1;
  localparam step_t STEP_VERSION     = 3'd2;
  localparam step_t STEP_TYPE        = 3'd3;
  localparam step_t STEP_LEN_LO      = 3'd4;
  localparam step_t STEP_LEN_HI      = 3'd5;
  localparam step_t STEP_CRC_LO      = 3'd6;
  localparam step_t STEP_CRC_HI      = 3'd7;

  // CRC-16, poly 0x1021, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: sv/frame_builder_crc16_core.sv
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall | fbc_pkg::in_item_t
// out_    | output    | out_valid/out_stall | fbc_pkg::out_item_t
// APB     | input     | psel/penable/pready | 4 registers at byte address 4*i
//
// The front classifies one input transaction per cycle into a 4-entry command
// queue; in_stall rises only when that queue is full. The back emits one
// result byte per cycle unless out_stall: 1 for a payload byte, 3 for the
// final byte of a frame, 6 (8 at zero length) for a start, 1 for an error.
// Sustained input rate is one transaction per cycle on payload bytes unless
// out_stall; header and trailer bursts drain from the queue behind them.
// Reset is synchronous on rst_n and restores the register defaults.
module frame_builder_crc16_core #(
  parameter int unsigned QUEUE_DEPTH = fbc_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  fbc_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output fbc_pkg::out_item_t           out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fbc_pkg::PADDR_W-1:0]  paddr,
  input  logic [fbc_pkg::PDATA_W-1:0]  pwdata,
  output logic [fbc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  logic [7:0]    sync_first_r, sync_second_r, version_r;
  logic [15:0]   max_payload_r;
  logic          wr_en;
  logic          push, queue_full, pop, head_valid;
  fbc_pkg::cmd_t push_cmd, head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= fbc_pkg::SYNC_FIRST_RST;
      sync_second_r <= fbc_pkg::SYNC_SECOND_RST;
      version_r     <= fbc_pkg::VERSION_RST;
      max_payload_r <= fbc_pkg::MAX_PAYLOAD_RST;
    end else if (wr_en) begin
      unique case (fbc_pkg::reg_idx_t'(paddr[3:2]))
        fbc_pkg::REG_SYNC_FIRST:  sync_first_r  <= pwdata[7:0];
        fbc_pkg::REG_SYNC_SECOND: sync_second_r <= pwdata[7:0];
        fbc_pkg::REG_VERSION:     version_r     <= pwdata[7:0];
        fbc_pkg::REG_MAX_PAYLOAD: max_payload_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    prdata = '0;
    unique case (fbc_pkg::reg_idx_t'(paddr[3:2]))
      fbc_pkg::REG_SYNC_FIRST:  prdata[7:0]  = sync_first_r;
      fbc_pkg::REG_SYNC_SECOND: prdata[7:0]  = sync_second_r;
      fbc_pkg::REG_VERSION:     prdata[7:0]  = version_r;
      fbc_pkg::REG_MAX_PAYLOAD: prdata[15:0] = max_payload_r;
      default: ;
    endcase
  end

  fbc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .max_payload (max_payload_r),
    .queue_full  (queue_full),
    .push        (push),
    .cmd         (push_cmd)
  );

  fbc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  fbc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .sync_first       (sync_first_r),
    .sync_second      (sync_second_r),
    .protocol_version (version_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data)
  );

endmodule

// File: sv/fbc_front.sv
module fbc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fbc_pkg::in_item_t  in_data,
  input  logic [15:0]        max_payload,
  input  logic               queue_full,
  output logic               push,
  output fbc_pkg::cmd_t      cmd
);

  logic        frame_open_r, frame_open_nxt;
  logic [15:0] remaining_r, remaining_nxt;

  // Stall only on a full queue
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Classify the transaction and track the open frame
  always_comb begin
    cmd            = '0;
    frame_open_nxt = frame_open_r;
    remaining_nxt  = remaining_r;
    if (in_data.operation == fbc_pkg::OP_START) begin
      if (in_data.payload_length > max_payload) begin
        cmd.kind = fbc_pkg::CMD_REFUSE;
      end else begin
        cmd.kind         = fbc_pkg::CMD_START;
        cmd.value        = in_data.frame_type;
        cmd.length       = in_data.payload_length;
        cmd.with_trailer = (in_data.payload_length == 16'd0);
        frame_open_nxt   = (in_data.payload_length != 16'd0);
        remaining_nxt    = in_data.payload_length;
      end
    end else begin
      if (!frame_open_r || remaining_r == 16'd0) begin
        cmd.kind = fbc_pkg::CMD_NO_FRAME;
      end else begin
        cmd.kind         = fbc_pkg::CMD_DATA;
        cmd.value        = in_data.data_byte;
        cmd.with_trailer = (remaining_r == 16'd1);
        frame_open_nxt   = (remaining_r != 16'd1);
        remaining_nxt    = remaining_r - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      remaining_r  <= '0;
    end else if (push) begin
      frame_open_r <= frame_open_nxt;
      remaining_r  <= remaining_nxt;
    end
  end

`ifndef SYNTHESIS
  // Open flag and byte count move together
  a_open_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    frame_open_r == (remaining_r != 16'd0))
    else $error("frame open flag disagrees with remaining count");
`endif

endmodule

// File: sv/fbc_queue.sv
module fbc_queue #(
  parameter int unsigned DEPTH = fbc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fbc_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output fbc_pkg::cmd_t  head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  fbc_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (!push && do_pop) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("command queue overflow");
`endif

endmodule

// File: sv/fbc_back.sv
module fbc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  fbc_pkg::cmd_t       head,
  output logic                pop,
  input  logic [7:0]          sync_first,
  input  logic [7:0]          sync_second,
  input  logic [7:0]          protocol_version,
  output logic                out_valid,
  input  logic                out_stall,
  output fbc_pkg::out_item_t  out_data
);

  fbc_pkg::step_t     step_r, step_nxt;
  logic [15:0]        crc_r, crc_base;
  fbc_pkg::out_item_t out_r, res;
  logic               out_valid_r;
  logic               load, fire, cmd_done, crc_en;

  // Output register loads when empty or being taken
  assign load = !out_valid_r || !out_stall;
  assign fire = load && head_valid;
  assign pop  = fire && cmd_done;

  // Byte selection for the current step of the head command
  always_comb begin
    res       = '0;
    cmd_done  = 1'b0;
    crc_en    = 1'b0;
    crc_base  = crc_r;
    step_nxt  = step_r + 3'd1;
    if ((head.kind == fbc_pkg::CMD_START || head.kind == fbc_pkg::CMD_DATA) &&
        step_r == fbc_pkg::STEP_CRC_LO) begin
      res.out_byte = crc_r[7:0];
    end else if ((head.kind == fbc_pkg::CMD_START || head.kind == fbc_pkg::CMD_DATA) &&
                 step_r == fbc_pkg::STEP_CRC_HI) begin
      res.out_byte      = crc_r[15:8];
      res.last_of_frame = 1'b1;
      cmd_done          = 1'b1;
    end else begin
      unique case (head.kind)
        fbc_pkg::CMD_START: begin
          case (step_r)
            fbc_pkg::STEP_SYNC_FIRST:  res.out_byte = sync_first;
            fbc_pkg::STEP_SYNC_SECOND: res.out_byte = sync_second;
            fbc_pkg::STEP_VERSION: begin
              res.out_byte = protocol_version;
              crc_en       = 1'b1;
              crc_base     = fbc_pkg::CRC_INIT;
            end
            fbc_pkg::STEP_TYPE: begin
              res.out_byte = head.value;
              crc_en       = 1'b1;
            end
            fbc_pkg::STEP_LEN_LO: begin
              res.out_byte = head.length[7:0];
              crc_en       = 1'b1;
            end
            default: begin
              res.out_byte = head.length[15:8];
              crc_en       = 1'b1;
              cmd_done     = !head.with_trailer;
            end
          endcase
        end
        fbc_pkg::CMD_DATA: begin
          res.out_byte = head.value;
          crc_en       = 1'b1;
          cmd_done     = !head.with_trailer;
          step_nxt     = fbc_pkg::STEP_CRC_LO;
        end
        fbc_pkg::CMD_REFUSE: begin
          res.last_of_frame = 1'b1;
          res.status        = fbc_pkg::STATUS_TOO_LONG;
          cmd_done          = 1'b1;
        end
        default: begin
          res.last_of_frame = 1'b1;
          res.status        = fbc_pkg::STATUS_NO_FRAME;
          cmd_done          = 1'b1;
        end
      endcase
    end
    if (cmd_done) begin
      step_nxt = fbc_pkg::STEP_SYNC_FIRST;
    end
  end

  // Sequencer step and running CRC
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= fbc_pkg::STEP_SYNC_FIRST;
      crc_r  <= fbc_pkg::CRC_INIT;
    end else if (fire) begin
      step_r <= step_nxt;
      if (crc_en) begin
        crc_r <= fbc_pkg::crc16_byte(crc_base, res.out_byte);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // A command part-way through emission stays at the queue head
  a_step_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != fbc_pkg::STEP_SYNC_FIRST |-> head_valid)
    else $error("sequencer mid-command with empty queue");

  // Error results always close the transaction group
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != fbc_pkg::STATUS_OK |-> out_r.last_of_frame)
    else $error("error result without last flag");

  // Refusal and stray-byte commands never sit mid-sequence
  a_single_step_errors: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid && (head.kind == fbc_pkg::CMD_REFUSE ||
                   head.kind == fbc_pkg::CMD_NO_FRAME)
    |-> step_r == fbc_pkg::STEP_SYNC_FIRST)
    else $error("error command with non-zero step");
`endif

endmodule
